[src/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DefaultDepth     = 16;
  localparam int DefaultDataWidth = 32;

  localparam int DataInWidth  = 32;
  localparam int DataOutWidth = 32;
  localparam int FillWidth    = 5;

  typedef enum logic [1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_POP_BACK   = 2'd1,
    MODE_PUSH_FRONT = 2'd2,
    MODE_POP_FRONT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_e;

  typedef struct packed {
    mode_e                  mode;
    logic [DataInWidth-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic [DataOutWidth-1:0] data_out;
    status_e                 status;
    logic [FillWidth-1:0]    fill_count;
  } out_t;

endpackage

[src/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque in a circular single-port store with registered read data.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | in_data_i  (deq_pkg::in_t)
//   out     | output    | out_valid_o / out_stall_i  | out_data_o (deq_pkg::out_t)
//
// a beat is handled in order: accept with pointer update and store access,
// then the store read data is captured into the output register.
// the single store port and its registered read set this order.
// one result beat per input beat; the next input beat is taken while a
// result still waits in the output register.
// a stalled output holds the response state, which holds off input.
// reset clears pointers, fill level and valids; the store needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DefaultDepth,
  parameter int DATA_WIDTH = deq_pkg::DefaultDataWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  deq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output deq_pkg::out_t out_data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  deq_pkg::state_e state_q, state_d;
  logic [AW-1:0]   front_q, front_d;
  logic [AW-1:0]   back_q, back_d;
  logic [CW-1:0]   occ_q, occ_d;

  logic            pop_ok_q, pop_ok_d;
  deq_pkg::status_e status_q, status_d;
  logic [CW-1:0]   fill_q;

  logic            out_valid_q;
  deq_pkg::out_t   out_q;

  logic            in_fire;
  logic            out_free;
  logic            load_out;
  logic            is_push;
  logic            full;
  logic            empty;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_addr;
  logic [AW-1:0]   front_inc, front_dec, back_inc, back_dec;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (occ_q == CW'(DEPTH));
  assign empty    = (occ_q == '0);
  assign is_push  = (in_data_i.mode == deq_pkg::MODE_PUSH_BACK) ||
                    (in_data_i.mode == deq_pkg::MODE_PUSH_FRONT);

  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
  assign back_inc  = (back_q == AW'(DEPTH - 1)) ? '0 : back_q + 1'b1;
  assign back_dec  = (back_q == '0) ? AW'(DEPTH - 1) : back_q - 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::ST_IDLE: begin
        if (in_fire) state_d = deq_pkg::ST_RESP;
      end
      deq_pkg::ST_RESP: begin
        if (out_free) state_d = deq_pkg::ST_IDLE;
      end
      default: state_d = deq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      deq_pkg::ST_IDLE: in_stall_o = 1'b0;
      deq_pkg::ST_RESP: load_out   = out_free;
      default: ;
    endcase
  end

  // operation decode, pointer update and store access
  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    occ_d    = occ_q;
    pop_ok_d = 1'b0;
    status_d = deq_pkg::STATUS_OK;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = back_q;
    if (in_fire) begin
      if (is_push && full) begin
        status_d = deq_pkg::STATUS_FULL;
      end else if (!is_push && empty) begin
        status_d = deq_pkg::STATUS_EMPTY;
      end else begin
        unique case (in_data_i.mode)
          deq_pkg::MODE_PUSH_BACK: begin
            mem_we   = 1'b1;
            mem_addr = back_q;
            back_d   = back_inc;
            occ_d    = occ_q + 1'b1;
          end
          deq_pkg::MODE_POP_BACK: begin
            mem_re   = 1'b1;
            mem_addr = back_dec;
            back_d   = back_dec;
            occ_d    = occ_q - 1'b1;
            pop_ok_d = 1'b1;
          end
          deq_pkg::MODE_PUSH_FRONT: begin
            mem_we   = 1'b1;
            mem_addr = front_dec;
            front_d  = front_dec;
            occ_d    = occ_q + 1'b1;
          end
          deq_pkg::MODE_POP_FRONT: begin
            mem_re   = 1'b1;
            mem_addr = front_q;
            front_d  = front_inc;
            occ_d    = occ_q - 1'b1;
            pop_ok_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // word store, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= DATA_WIDTH'(in_data_i.data_in);
    if (mem_re) rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      occ_q   <= occ_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response info held for the read cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pop_ok_q <= pop_ok_d;
      status_q <= status_d;
      fill_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.data_out   <= pop_ok_q ? deq_pkg::DataOutWidth'(rd_q) : '0;
      out_q.status     <= status_q;
      out_q.fill_count <= deq_pkg::FillWidth'(fill_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("fill level above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty || full) |-> (front_q == back_q))
    else $error("pointers disagree with fill level");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_push && full) |=> ($stable(occ_q) && $stable(front_q) && $stable(back_q)))
    else $error("push into full store changed state");

  a_fire_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == deq_pkg::ST_RESP))
    else $error("accepted beat without response cycle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != deq_pkg::STATUS_OK)) |-> (out_q.data_out == '0))
    else $error("error beat carries data");
`endif

endmodule

[sim/double_ended_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives push and pop operations at both ends of the deque, predicts each
// response from a local model of the store, pointers and fill level, and
// checks every response beat field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;

  localparam int Depth      = deq_pkg::DefaultDepth;
  localparam int PtrWidth   = $clog2(Depth);
  localparam int HoldCycles = 60;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 340;

  typedef struct {
    deq_pkg::in_t beat;
    int           phase;
    bit           drain;
    bit           hold;
  } op_item_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic          in_valid    = 1'b0;
  logic          in_stall_o;
  deq_pkg::in_t  in_beat     = '0;
  logic          out_valid_o;
  logic          out_stall   = 1'b0;
  deq_pkg::out_t out_data_o;

  op_item_t      op_queue[$];
  deq_pkg::out_t predicted_resp[$];

  logic [deq_pkg::DataInWidth-1:0] words [Depth];
  logic [PtrWidth-1:0]             front_ptr = '0;
  logic [PtrWidth-1:0]             back_ptr  = '0;
  logic [deq_pkg::FillWidth-1:0]   level     = '0;

  int tx_idle_pct[3]  = '{10, 49, 0};
  int rx_stall_pct[3] = '{49, 10, 0};
  int push_bias[3]    = '{15, 50, 85};

  int   phase     = 0;
  int   n_sent    = 0;
  int   n_checked = 0;
  int   n_errors  = 0;
  int   hold_cnt  = 0;
  int   cycles    = 0;
  logic hold_start = 1'b0;
  bit   launch;
  deq_pkg::out_t got;
  deq_pkg::out_t want;

  double_ended_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (words[i]) words[i] = '0;
  end

  // deque model: one response per operation
  function automatic deq_pkg::out_t deque_apply(deq_pkg::in_t beat);
    deq_pkg::out_t res;
    logic is_push;
    res.data_out   = '0;
    res.status     = deq_pkg::STATUS_OK;
    is_push = (beat.mode == deq_pkg::MODE_PUSH_BACK) ||
              (beat.mode == deq_pkg::MODE_PUSH_FRONT);
    if (is_push && level >= Depth) begin
      res.status = deq_pkg::STATUS_FULL;
    end else if (!is_push && level == 0) begin
      res.status = deq_pkg::STATUS_EMPTY;
    end else begin
      case (beat.mode)
        deq_pkg::MODE_PUSH_BACK: begin
          words[back_ptr] = beat.data_in;
          back_ptr = back_ptr + 1'b1;
          level = level + 1'b1;
        end
        deq_pkg::MODE_POP_BACK: begin
          back_ptr = back_ptr - 1'b1;
          res.data_out = words[back_ptr];
          level = level - 1'b1;
        end
        deq_pkg::MODE_PUSH_FRONT: begin
          front_ptr = front_ptr - 1'b1;
          words[front_ptr] = beat.data_in;
          level = level + 1'b1;
        end
        default: begin
          res.data_out = words[front_ptr];
          front_ptr = front_ptr + 1'b1;
          level = level - 1'b1;
        end
      endcase
    end
    res.fill_count = level;
    return res;
  endfunction

  task automatic add_op(deq_pkg::mode_e m, logic [deq_pkg::DataInWidth-1:0] d, int ph,
                        bit drain, bit hold);
    op_item_t it;
    it.beat.mode    = m;
    it.beat.data_in = d;
    it.phase        = ph;
    it.drain        = drain;
    it.hold         = hold;
    op_queue.insert(op_queue.size(), it);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_beat    <= '0;
      n_sent     <= 0;
      hold_start <= 1'b0;
      phase      <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predicted_resp.insert(predicted_resp.size(), deque_apply(in_beat));
      end
      n_sent <= n_sent + ((in_valid && !in_stall_o) ? 1 : 0);
      launch = 1'b0;
      if (!(in_valid && in_stall_o) && op_queue.size() != 0) begin
        launch = $urandom_range(99) >= tx_idle_pct[op_queue[0].phase];
        if (op_queue[0].drain && (in_valid || n_sent != n_checked)) launch = 1'b0;
      end
      hold_start <= launch && op_queue[0].hold;
      if (launch) begin
        in_valid <= 1'b1;
        in_beat  <= op_queue[0].beat;
        phase    <= op_queue[0].phase;
        op_queue.delete(0);
      end else if (!(in_valid && in_stall_o)) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and response stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      n_checked <= 0;
      hold_cnt  <= 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        n_checked <= n_checked + 1;
        got = out_data_o;
        if (predicted_resp.size() == 0) begin
          $error("unexpected beat: data_out %h status %0d fill_count %0d",
                 got.data_out, got.status, got.fill_count);
          n_errors++;
        end else begin
          want = predicted_resp[0];
          predicted_resp.delete(0);
          if (got.data_out !== want.data_out) begin
            $error("data_out: expected %h, got %h", want.data_out, got.data_out);
            n_errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_errors++;
          end
          if (got.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
            n_errors++;
          end
        end
      end
      if (hold_start) begin
        hold_cnt <= HoldCycles;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end
      out_stall <= hold_start || hold_cnt > 1 || $urandom_range(99) < rx_stall_pct[phase];
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int    n;
    int    seg;
    int    bias;
    logic [deq_pkg::DataInWidth-1:0] d;
    deq_pkg::mode_e m;

    // empty pops, both ends, then extreme words
    add_op(deq_pkg::MODE_POP_BACK,   '1, 0, 0, 0);
    add_op(deq_pkg::MODE_POP_FRONT,  '1, 0, 0, 0);
    add_op(deq_pkg::MODE_PUSH_BACK,  '1, 0, 0, 0);
    add_op(deq_pkg::MODE_PUSH_FRONT, '0, 0, 0, 0);
    add_op(deq_pkg::MODE_POP_BACK,   '0, 0, 0, 0);
    add_op(deq_pkg::MODE_POP_FRONT,  '1, 0, 0, 0);
    // fill to the top from both ends, wrapping the front pointer
    for (int i = 0; i < Depth; i++) begin
      d = (i % 2) ? 32'haaaa_aaaa ^ i : 32'h5555_5555 ^ i;
      add_op((i % 3 == 0) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK, d, 0, 0, 0);
    end
    add_op(deq_pkg::MODE_PUSH_BACK,  '1, 0, 0, 0);
    add_op(deq_pkg::MODE_PUSH_FRONT, '0, 0, 0, 0);

    for (int ph = 0; ph < 3; ph++) begin
      n = 0;
      while (n < PhaseItems) begin
        seg  = $urandom_range(12, 40);
        bias = push_bias[$urandom_range(2)];
        for (int k = 0; k < seg; k++) begin
          case ($urandom_range(7))
            0:       d = '0;
            1:       d = '1;
            default: d = $urandom;
          endcase
          if ($urandom_range(99) < bias) begin
            m = $urandom_range(1) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK;
          end else begin
            m = $urandom_range(1) ? deq_pkg::MODE_POP_FRONT : deq_pkg::MODE_POP_BACK;
          end
          add_op(m, d, ph, ph != 0 && n == 0, ph == 2 && n == 100);
          n++;
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (op_queue.size() != 0 || in_valid) @(posedge clk_i);
    while (n_checked != n_sent || predicted_resp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
